// ----- design/i12_pkg.sv -----
// package: operation codes, memory control type and default sizes for the i12 execute core
`timescale 1ns / 1ps

package i12_pkg;

  // default data memory address width in bits (byte addressed)
  localparam int MEM_ADDR_BITS_DEF = 16;

  // number of byte lanes (banks) of the data memory
  localparam int NUM_LANES = 4;

  typedef enum logic [2:0] {
    OP_ORI  = 3'd0,
    OP_ADDI = 3'd1,
    OP_ANDI = 3'd2,
    OP_SLTUI = 3'd3,
    OP_LDW  = 3'd4,
    OP_STW  = 3'd5,
    OP_LDB  = 3'd6,
    OP_STB  = 3'd7
  } i12_op_t;

  // per-cycle control of the banked data memory
  typedef struct packed {
    logic                 rd_en;
    logic [NUM_LANES-1:0] wr_mask;
  } i12_mem_ctl_t;

endpackage

// ----- design/i12_dmem.sv -----
// four-bank byte-wide data memory with registered read data
`timescale 1ns / 1ps

module i12_dmem #(
  parameter int ROW_BITS = i12_pkg::MEM_ADDR_BITS_DEF - 2
) (
  input  logic                  clk,
  input  i12_pkg::i12_mem_ctl_t ctl,
  input  logic [ROW_BITS-1:0]   row   [i12_pkg::NUM_LANES],
  input  logic [7:0]            wdata [i12_pkg::NUM_LANES],
  output logic [7:0]            rdata [i12_pkg::NUM_LANES]
);

  localparam int ROWS = 2 ** ROW_BITS;

  for (genvar b = 0; b < i12_pkg::NUM_LANES; b++) begin : g_bank
    logic [7:0] bank [ROWS];
    logic [7:0] rdata_r;

    always_ff @(posedge clk) begin
      if (ctl.wr_mask[b]) begin
        bank[row[b]] <= wdata[b];
      end
      if (ctl.rd_en) begin
        rdata_r <= bank[row[b]];
      end
    end

    assign rdata[b] = rdata_r;
  end

endmodule

// ----- design/i12_alu_load_store_execute_core.sv -----
// top level: pipelined execute core for 12-bit-immediate alu, load and store instructions
`timescale 1ns / 1ps

// Executes one instruction word per item: ori, addi.w, andi, sltui, ld.w, ld.b, st.w, st.b,
// against a 32 x 32-bit register file and a little-endian byte memory of 2^MEM_ADDR_BITS
// bytes. The operation comes in on in_tuser, the instruction word on in_tdata; each item
// gives exactly one result item. Sustained rate is one item per cycle while out_tready is
// high, with dependent instructions back to back (results, loaded data included, are
// forwarded into the address adder). The register file is read at acceptance, the address
// add plus memory access are registered into stage 2, and load alignment and register
// write go on into the output register.
// The data memory sits in four byte banks, so an unaligned word access touches
// each bank once in the same cycle. After reset a clearing pass zeroes one row of all four
// banks per cycle, 2^(MEM_ADDR_BITS-2) rows in total (16384 at the default), together with
// the register file; in_tready stays low until it is done.
module i12_alu_load_store_execute_core #(
  parameter int MEM_ADDR_BITS = i12_pkg::MEM_ADDR_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // input items
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // instr_word[31:0]
  input  logic [2:0]   in_tuser,   // action[2:0]
  // result items
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata   // dest_written[0], dest_index[5:1], dest_value[37:6],
                                   // store_done[38], effective_address[70:39],
                                   // store_data[102:71], zero pad[103]
);

  localparam int ROW_BITS = MEM_ADDR_BITS - 2;
  localparam int LANES    = i12_pkg::NUM_LANES;

  // clearing pass after reset
  logic [ROW_BITS-1:0] clr_cnt_r;
  logic                clr_done_r;

  // handshake and stage moves
  logic in_acc;
  logic adv1, adv2;
  logic ready2, ready3;

  // register file, two registered read ports
  logic [31:0] rf [32];
  logic [31:0] rfa_r, rfd_r;
  logic        rf_we;
  logic [4:0]  rf_widx;
  logic [31:0] rf_wdata;

  // last register file write, for the read that happened on the same edge
  logic        lw_v_r;
  logic [4:0]  lw_idx_r;
  logic [31:0] lw_val_r;

  // stage 1: operands, address, alu, memory access
  logic                v1_r;
  i12_pkg::i12_op_t    op1_r;
  logic [4:0]          rd1_r, rj1_r;
  logic [11:0]         imm1_r;
  logic [31:0]         a1, d1, simm1, uimm1, ea1, alu1;
  logic [1:0]          lane1;
  logic [ROW_BITS-1:0] row0, row1;
  logic                is_mem1;

  // stage 2: load alignment and write back
  logic             v2_r;
  i12_pkg::i12_op_t op2_r;
  logic [4:0]       rd2_r;
  logic [31:0]      alu2_r, ea2_r, sd2_r;
  logic [1:0]       lane2_r;
  logic             st2_r;
  logic [31:0]      ld_word, ld_byte, s2_raw, s2_val;
  logic             s2_wr;

  // output register
  logic         out_v_r;
  logic [103:0] out_data_r;

  // data memory interface
  i12_pkg::i12_mem_ctl_t mem_ctl;
  logic [ROW_BITS-1:0]   mem_row   [LANES];
  logic [7:0]            mem_wdata [LANES];
  logic [7:0]            mem_rdata [LANES];

  // newest value of a register as seen by stage 1
  function automatic logic [31:0] pick(input logic [4:0]  idx,
                                       input logic [31:0] rfv,
                                       input logic        s2_en,
                                       input logic [4:0]  s2_idx,
                                       input logic [31:0] s2_v,
                                       input logic        lw_en,
                                       input logic [4:0]  lw_idx,
                                       input logic [31:0] lw_v);
    logic [31:0] res;
    priority if (idx == 5'd0) begin
      res = '0;
    end else if (s2_en && (idx == s2_idx)) begin
      res = s2_v;
    end else if (lw_en && (idx == lw_idx)) begin
      res = lw_v;
    end else begin
      res = rfv;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- handshake
  assign ready3    = !out_v_r || out_tready;
  assign ready2    = !v2_r || ready3;
  assign adv2      = v2_r && ready3;
  assign adv1      = v1_r && ready2;
  assign in_tready = clr_done_r && (!v1_r || ready2);
  assign in_acc    = in_tvalid && in_tready;

  // ---------------------------------------------------------------- clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_done_r <= 1'b0;
    end else if (!clr_done_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (&clr_cnt_r) begin
        clr_done_r <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- register file
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[rf_widx] <= rf_wdata;
    end
    if (in_acc) begin
      rfa_r <= rf[in_tdata[9:5]];
      rfd_r <= rf[in_tdata[4:0]];
    end
  end

  // the clearing pass sweeps the file repeatedly, zeros only
  assign rf_we    = clr_done_r ? (adv2 && s2_wr) : 1'b1;
  assign rf_widx  = clr_done_r ? rd2_r : clr_cnt_r[4:0];
  assign rf_wdata = clr_done_r ? s2_val : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_v_r <= 1'b0;
    end else if (adv2 && s2_wr) begin
      lw_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s2_wr) begin
      lw_idx_r <= rd2_r;
      lw_val_r <= s2_val;
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_acc) begin
      v1_r <= 1'b1;
    end else if (adv1) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op1_r  <= i12_pkg::i12_op_t'(in_tuser);
      rd1_r  <= in_tdata[4:0];
      rj1_r  <= in_tdata[9:5];
      imm1_r <= in_tdata[21:10];
    end
  end

  always_comb begin
    a1 = pick(rj1_r, rfa_r, v2_r && s2_wr, rd2_r, s2_val, lw_v_r, lw_idx_r, lw_val_r);
    d1 = pick(rd1_r, rfd_r, v2_r && s2_wr, rd2_r, s2_val, lw_v_r, lw_idx_r, lw_val_r);
  end

  assign simm1   = {{20{imm1_r[11]}}, imm1_r};
  assign uimm1   = {20'd0, imm1_r};
  assign ea1     = a1 + simm1;
  assign lane1   = ea1[1:0];
  assign row0    = ea1[MEM_ADDR_BITS-1:2];
  assign row1    = row0 + 1'b1;
  assign is_mem1 = (op1_r == i12_pkg::OP_LDW) || (op1_r == i12_pkg::OP_STW) ||
                   (op1_r == i12_pkg::OP_LDB) || (op1_r == i12_pkg::OP_STB);

  always_comb begin
    unique case (op1_r)
      i12_pkg::OP_ORI:   alu1 = a1 | uimm1;
      i12_pkg::OP_ADDI:  alu1 = ea1;
      i12_pkg::OP_ANDI:  alu1 = a1 & uimm1;
      i12_pkg::OP_SLTUI: alu1 = {31'd0, (a1 < simm1)};
      default:           alu1 = '0;
    endcase
  end

  // memory access: bank b holds bytes whose address ends in b; lanes below the start lane
  // belong to the next row
  always_comb begin
    logic [1:0] sel;
    mem_ctl.rd_en   = adv1;
    mem_ctl.wr_mask = '0;
    for (int b = 0; b < LANES; b++) begin
      sel = 2'(b) - lane1;
      if (!clr_done_r) begin
        mem_row[b]   = clr_cnt_r;
        mem_wdata[b] = 8'd0;
      end else begin
        mem_row[b]   = (2'(b) < lane1) ? row1 : row0;
        mem_wdata[b] = (op1_r == i12_pkg::OP_STW) ? d1[{sel, 3'b000} +: 8] : d1[7:0];
      end
    end
    if (!clr_done_r) begin
      mem_ctl.wr_mask = '1;
    end else if (adv1 && (op1_r == i12_pkg::OP_STW)) begin
      mem_ctl.wr_mask = '1;
    end else if (adv1 && (op1_r == i12_pkg::OP_STB)) begin
      mem_ctl.wr_mask = LANES'(1) << lane1;
    end
  end

  i12_dmem #(
    .ROW_BITS (ROW_BITS)
  ) u_dmem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .row   (mem_row),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // ---------------------------------------------------------------- stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv1) begin
      v2_r <= 1'b1;
    end else if (adv2) begin
      v2_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      op2_r   <= op1_r;
      rd2_r   <= rd1_r;
      alu2_r  <= alu1;
      lane2_r <= lane1;
      ea2_r   <= is_mem1 ? ea1 : 32'd0;
      st2_r   <= (op1_r == i12_pkg::OP_STW) || (op1_r == i12_pkg::OP_STB);
      unique case (op1_r)
        i12_pkg::OP_STW: sd2_r <= d1;
        i12_pkg::OP_STB: sd2_r <= {24'd0, d1[7:0]};
        default:         sd2_r <= '0;
      endcase
    end
  end

  // gather bytes back in address order starting at the start lane
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      ld_word[8*k +: 8] = mem_rdata[lane2_r + 2'(k)];
    end
    ld_byte = {{24{mem_rdata[lane2_r][7]}}, mem_rdata[lane2_r]};
  end

  always_comb begin
    unique case (op2_r)
      i12_pkg::OP_LDW: s2_raw = ld_word;
      i12_pkg::OP_LDB: s2_raw = ld_byte;
      default:         s2_raw = alu2_r;
    endcase
  end

  // stores and r0 destinations write nothing
  assign s2_wr  = !st2_r && (rd2_r != 5'd0);
  assign s2_val = s2_wr ? s2_raw : 32'd0;

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv2) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      out_data_r <= {1'b0, sd2_r, ea2_r, st2_r, s2_val, rd2_r, s2_wr};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------- assertions
  // no item enters while the memories are being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_done_r |-> !in_tready)
    else $error("item accepted during clearing pass");

  // an accepted item always finds stage 1 free or emptying
  a_stage1_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (!v1_r || adv1))
    else $error("stage 1 overwritten");

  // normal operation never writes register zero
  a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
    (rf_we && clr_done_r) |-> (rf_widx != 5'd0))
    else $error("register zero written");

  // a store never also reports a register write
  a_store_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[38]))
    else $error("store reported a register write");

  // a finished stage 2 item reaches the output register on the next edge
  a_adv_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv2 |=> out_v_r)
    else $error("result lost between stage 2 and output");

endmodule
